### sv/coons_patch_grid_evaluator_macros.svh
// Assertion macros for the Coons patch grid evaluator.
// Used by the top level only; relies on clk and arst_n in the including scope.
`ifndef COONS_PATCH_GRID_EVALUATOR_MACROS_SVH
`define COONS_PATCH_GRID_EVALUATOR_MACROS_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define CPG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpg assertion failed");
// antecedent implies consequent a fixed number of cycles later
`define CPG_ASSERT_DLY(lbl, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("cpg assertion failed");
`else
`define CPG_ASSERT_IMP(lbl, ante, cons)
`define CPG_ASSERT_DLY(lbl, ante, dly, cons)
`endif
`endif

### sv/cpg_pkg.sv
// Package for the Coons patch grid evaluator: widths, types, helpers.
// No dependencies; imported by coons_patch_grid_evaluator.
`default_nettype none
package cpg_pkg;
	localparam int GRID_INDEX_BITS  = 8;
	localparam int COORD_WIDTH      = 16;
	localparam int POINTS_PER_CURVE = 4;
	localparam int NUM_CURVES       = 4;
	localparam int TABLE_DEPTH      = NUM_CURVES * POINTS_PER_CURVE;
	localparam int TABLE_AW         = $clog2(TABLE_DEPTH);
	localparam int DIM_W            = GRID_INDEX_BITS + 1;
	localparam int FRAC_W           = 17;
	localparam int CP_W             = 28;
	localparam int LERP_W           = 46;
	localparam int SUM_W            = 48;
	localparam int VIDX_W           = 16;
	localparam int PIPE_LAT         = 11;

	localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);
	localparam logic [DIM_W-1:0]  DIM_MIN = DIM_W'(2);
	localparam logic [DIM_W-1:0]  DIM_MAX = DIM_W'(2**GRID_INDEX_BITS);

	// register addresses (word index)
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic [TABLE_AW-1:0] addr;
		coord_t              x;
		coord_t              y;
		coord_t              z;
	} load_t;

	typedef struct packed {
		logic              v;
		logic              ev;
		logic [VIDX_W-1:0] vidx;
	} ctl_t;

	// four restoring division steps: returns {quotient bits, remainder}
	function automatic logic [11:0] div4(input logic [7:0] r_in, input logic [3:0] nb,
		input logic [7:0] d);
		logic [7:0] r;
		logic [8:0] t;
		logic [3:0] q;
		r = r_in;
		q = '0;
		for (int k = 3; k >= 0; k--) begin
			t = {r, nb[k]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				q[k] = 1'b1;
			end
			r = t[7:0];
		end
		return {q, r};
	endfunction

	// saturate a rounded sum to the coordinate width
	function automatic coord_t sat_coord(input logic signed [23:0] v);
		logic signed [23:0] hi;
		logic signed [23:0] lo;
		hi = 24'sd2 ** (COORD_WIDTH - 1) - 24'sd1;
		lo = -hi - 24'sd1;
		if (v > hi) return coord_t'(hi);
		else if (v < lo) return coord_t'(lo);
		else return coord_t'(v);
	endfunction
endpackage
`default_nettype wire

### sv/coons_patch_grid_evaluator.sv
// Coons patch grid evaluator, top level: control point table, pipeline, APB registers.
// Depends on cpg_pkg and coons_patch_grid_evaluator_macros.svh.
//
// A fully pipelined evaluator: one word (load or evaluate) is taken every cycle, so busy
// stays low. An evaluate word yields its result strobe after passing the eleven-stage chain:
// index clamping, four stages of the grid fraction divider, two for the Bernstein weights,
// then curve products, curve sums, blend products and final rounding. Load words produce
// no result; they update the table in order with evaluations. Results are shown for one
// cycle with result_valid and the receiver cannot stall them.
`default_nettype none
`include "coons_patch_grid_evaluator_macros.svh"
module coons_patch_grid_evaluator (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [2:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic                 mode,
	input  wire logic [1:0]           curve_select,
	input  wire logic [1:0]           point_select,
	input  wire cpg_pkg::coord_t      point_x,
	input  wire cpg_pkg::coord_t      point_y,
	input  wire cpg_pkg::coord_t      point_z,
	input  wire logic [7:0]           grid_i,
	input  wire logic [7:0]           grid_j,
	output logic                      result_valid,
	output logic [15:0]               vertex_index,
	output cpg_pkg::coord_t           pos_x,
	output cpg_pkg::coord_t           pos_y,
	output cpg_pkg::coord_t           pos_z,
	output logic [7:0]                color_r,
	output logic [7:0]                color_g,
	output logic [7:0]                color_b
);
	import cpg_pkg::*;

	// registers and table
	logic [DIM_W-1:0] grid_columns_q, grid_rows_q;
	coord_t           tbl_q [TABLE_DEPTH][3];

	// pipeline control and load words
	ctl_t  ctl_s [1:PIPE_LAT];
	load_t ld_s  [1:7];

	// divider
	logic [7:0]        idx_s1 [2], dv_s1 [2];
	logic [FRAC_W-1:0] q_s2 [2], q_s3 [2], q_s4 [2];
	logic [7:0]        r_s2 [2], r_s3 [2], r_s4 [2];
	logic [7:0]        dv_s2 [2], dv_s3 [2], dv_s4 [2];
	logic [FRAC_W-1:0] frac_s5 [2], frac_s6 [2], frac_s7 [2], frac_s8 [2], frac_s9 [2];

	// weights and colours
	logic [33:0]       uu_s6 [2], vv_s6 [2], uv_s6 [2];
	logic [33:0]       crw_s6, cst_s6, cbw_s6;
	logic [FRAC_W-1:0] w_s7 [2][4];
	logic [7:0]        col_s7 [3], col_s8 [3], col_s9 [3], col_s10 [3];

	// geometry
	logic signed [33:0]     pc_s8 [4][3][4];
	logic signed [33:0]     pb_s8 [2][3][2];
	logic signed [CP_W-1:0] cp_s9 [4][3];
	logic signed [CP_W-1:0] bp_s9 [2][3];
	logic signed [LERP_W-1:0] lp_s10 [3][6];

	// APB register port
	assign pready = 1'b1;
	assign busy   = 1'b0;
	always_comb begin
		unique case (paddr[2])
			REG_COLUMNS: prdata = {{(32-DIM_W){1'b0}}, grid_columns_q};
			REG_ROWS:    prdata = {{(32-DIM_W){1'b0}}, grid_rows_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= DIM_W'(20);
			grid_rows_q    <= DIM_W'(20);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_COLUMNS: grid_columns_q <= pwdata[DIM_W-1:0];
				REG_ROWS:    grid_rows_q    <= pwdata[DIM_W-1:0];
				default:     ;
			endcase
		end
	end

	// stage 1: clamp grid size and indices, vertex index
	logic              acc;
	logic [DIM_W-1:0]  m_c, n_c;
	logic [7:0]        dm_c, dn_c, i_c, j_c;
	logic [16:0]       vidx_c;
	always_comb begin
		acc = start && !busy;
		m_c = (grid_columns_q < DIM_MIN) ? DIM_MIN :
			(grid_columns_q > DIM_MAX) ? DIM_MAX : grid_columns_q;
		n_c = (grid_rows_q < DIM_MIN) ? DIM_MIN :
			(grid_rows_q > DIM_MAX) ? DIM_MAX : grid_rows_q;
		dm_c = 8'(m_c - DIM_W'(1));
		dn_c = 8'(n_c - DIM_W'(1));
		i_c  = (grid_i > dm_c) ? dm_c : grid_i;
		j_c  = (grid_j > dn_c) ? dn_c : grid_j;
		vidx_c = 17'(j_c * m_c) + {9'b0, i_c};
	end

	// valid and control chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PIPE_LAT; k++) ctl_s[k] <= '0;
		end else begin
			ctl_s[1] <= '{v: acc, ev: mode, vidx: vidx_c[VIDX_W-1:0]};
			for (int k = 2; k <= PIPE_LAT; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	// load words ride along to the table stage
	always_ff @(posedge clk) begin
		ld_s[1] <= '{addr: {curve_select, point_select}, x: point_x, y: point_y, z: point_z};
		for (int k = 2; k <= 7; k++) ld_s[k] <= ld_s[k-1];
	end

	// control point table, written when a load word reaches stage 7
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < TABLE_DEPTH; e++)
				for (int a = 0; a < 3; a++) tbl_q[e][a] <= '0;
		end else if (ctl_s[7].v && !ctl_s[7].ev) begin
			tbl_q[ld_s[7].addr][0] <= ld_s[7].x;
			tbl_q[ld_s[7].addr][1] <= ld_s[7].y;
			tbl_q[ld_s[7].addr][2] <= ld_s[7].z;
		end
	end

	// stages 1 to 5: s = (i*65536 + d/2) / d, four quotient bits per stage after stage 1
	always_ff @(posedge clk) begin
		logic [11:0] res;
		logic        q16;
		idx_s1[0] <= i_c;
		idx_s1[1] <= j_c;
		dv_s1[0]  <= dm_c;
		dv_s1[1]  <= dn_c;
		for (int d = 0; d < 2; d++) begin
			q16 = (idx_s1[d] == dv_s1[d]);
			res = div4(q16 ? 8'd0 : idx_s1[d], 4'd0, dv_s1[d]);
			q_s2[d]  <= {q16, res[11:8], 12'b0};
			r_s2[d]  <= res[7:0];
			dv_s2[d] <= dv_s1[d];

			res = div4(r_s2[d], 4'd0, dv_s2[d]);
			q_s3[d]  <= {q_s2[d][16:12], res[11:8], 8'b0};
			r_s3[d]  <= res[7:0];
			dv_s3[d] <= dv_s2[d];

			res = div4(r_s3[d], {1'b0, dv_s3[d][7:5]}, dv_s3[d]);
			q_s4[d]  <= {q_s3[d][16:8], res[11:8], 4'b0};
			r_s4[d]  <= res[7:0];
			dv_s4[d] <= dv_s3[d];

			res = div4(r_s4[d], dv_s4[d][4:1], dv_s4[d]);
			frac_s5[d] <= {q_s4[d][16:4], res[11:8]};
		end
	end

	// stage 6: squares and cross products of u and 1-u, colour weight products
	always_ff @(posedge clk) begin
		logic [FRAC_W-1:0] u, v;
		for (int d = 0; d < 2; d++) begin
			u = frac_s5[d];
			v = ONE_Q16 - u;
			uu_s6[d]   <= 34'(u * u);
			vv_s6[d]   <= 34'(v * v);
			uv_s6[d]   <= 34'(u * v);
			frac_s6[d] <= u;
		end
		crw_s6 <= 34'((ONE_Q16 - frac_s5[0]) * (ONE_Q16 - frac_s5[1]));
		cst_s6 <= 34'(frac_s5[0] * frac_s5[1]);
		cbw_s6 <= 34'(frac_s5[0] * (ONE_Q16 - frac_s5[1]));
	end

	// stage 7: cubic Bernstein weights rounded to Q16, colour channels
	always_ff @(posedge clk) begin
		logic [FRAC_W-1:0] u, v;
		logic [51:0]       b [4];
		logic [34:0]       wr;
		logic [42:0]       cr, cb;
		logic [25:0]       cg;
		for (int d = 0; d < 2; d++) begin
			u = frac_s6[d];
			v = ONE_Q16 - u;
			b[0] = 52'(vv_s6[d] * v);
			b[1] = 52'(uv_s6[d] * v);
			b[1] = b[1] + (b[1] << 1);
			b[2] = 52'(uv_s6[d] * u);
			b[2] = b[2] + (b[2] << 1);
			b[3] = 52'(uu_s6[d] * u);
			for (int k = 0; k < 4; k++)
				w_s7[d][k] <= FRAC_W'((b[k] + 52'h0_8000_0000) >> 32);
			frac_s7[d] <= u;
		end
		wr = {1'b0, crw_s6} + {1'b0, cst_s6};
		cr = ({8'b0, wr} << 8) - {8'b0, wr} + 43'h0_8000_0000;
		cb = ({9'b0, cbw_s6} << 8) - {9'b0, cbw_s6} + 43'h0_8000_0000;
		cg = ({9'b0, frac_s6[1]} << 8) - {9'b0, frac_s6[1]} + 26'h8000;
		col_s7[0] <= cr[39:32];
		col_s7[1] <= cg[23:16];
		col_s7[2] <= cb[39:32];
	end

	// stage 8: weighted control points, corner lerp products for the bilinear term
	always_ff @(posedge clk) begin
		logic signed [17:0] ws, wsn;
		for (int c = 0; c < NUM_CURVES; c++)
			for (int a = 0; a < 3; a++)
				for (int k = 0; k < POINTS_PER_CURVE; k++)
					pc_s8[c][a][k] <= $signed({1'b0, w_s7[c/2][k]})
						* tbl_q[TABLE_AW'(c * POINTS_PER_CURVE + k)][a];
		ws  = $signed({1'b0, frac_s7[0]});
		wsn = $signed({1'b0, ONE_Q16 - frac_s7[0]});
		for (int e = 0; e < 2; e++)
			for (int a = 0; a < 3; a++) begin
				pb_s8[e][a][0] <= wsn * tbl_q[TABLE_AW'(e * POINTS_PER_CURVE)][a];
				pb_s8[e][a][1] <= ws * tbl_q[TABLE_AW'(e * POINTS_PER_CURVE + 3)][a];
			end
		frac_s8 <= frac_s7;
		col_s8  <= col_s7;
	end

	// stage 9: curve points and corner lerps, rounded by 8 bits
	always_ff @(posedge clk) begin
		logic signed [35:0] sc;
		logic signed [35:0] sb;
		for (int c = 0; c < NUM_CURVES; c++)
			for (int a = 0; a < 3; a++) begin
				sc = 36'(pc_s8[c][a][0]) + 36'(pc_s8[c][a][1])
					+ 36'(pc_s8[c][a][2]) + 36'(pc_s8[c][a][3]) + 36'sd128;
				cp_s9[c][a] <= CP_W'(sc >>> 8);
			end
		for (int e = 0; e < 2; e++)
			for (int a = 0; a < 3; a++) begin
				sb = 36'(pb_s8[e][a][0]) + 36'(pb_s8[e][a][1]) + 36'sd128;
				bp_s9[e][a] <= CP_W'(sb >>> 8);
			end
		frac_s9 <= frac_s8;
		col_s9  <= col_s8;
	end

	// stage 10: ruled surface and bilinear blend products
	always_ff @(posedge clk) begin
		logic signed [17:0] s, sn, t, tn;
		s  = $signed({1'b0, frac_s9[0]});
		sn = $signed({1'b0, ONE_Q16 - frac_s9[0]});
		t  = $signed({1'b0, frac_s9[1]});
		tn = $signed({1'b0, ONE_Q16 - frac_s9[1]});
		for (int a = 0; a < 3; a++) begin
			lp_s10[a][0] <= tn * cp_s9[0][a];
			lp_s10[a][1] <= t  * cp_s9[1][a];
			lp_s10[a][2] <= sn * cp_s9[2][a];
			lp_s10[a][3] <= s  * cp_s9[3][a];
			lp_s10[a][4] <= tn * bp_s9[0][a];
			lp_s10[a][5] <= t  * bp_s9[1][a];
		end
		col_s10 <= col_s9;
	end

	// stage 11: Lc + Ld - B, round by 24 bits, saturate
	coord_t pos_c [3];
	always_comb begin
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] sh;
		for (int a = 0; a < 3; a++) begin
			sum = SUM_W'(lp_s10[a][0]) + SUM_W'(lp_s10[a][1]) + SUM_W'(lp_s10[a][2])
				+ SUM_W'(lp_s10[a][3]) - SUM_W'(lp_s10[a][4]) - SUM_W'(lp_s10[a][5])
				+ 48'sd8388608;
			sh = sum >>> 24;
			pos_c[a] = sat_coord(sh[23:0]);
		end
	end

	always_ff @(posedge clk) begin
		vertex_index <= ctl_s[10].vidx;
		pos_x   <= pos_c[0];
		pos_y   <= pos_c[1];
		pos_z   <= pos_c[2];
		color_r <= col_s10[0];
		color_g <= col_s10[1];
		color_b <= col_s10[2];
	end

	assign result_valid = ctl_s[PIPE_LAT].v && ctl_s[PIPE_LAT].ev;

	// checks
	`CPG_ASSERT_DLY(a_eval_gives_result, start && !busy && mode, PIPE_LAT, result_valid)
	`CPG_ASSERT_DLY(a_load_gives_none, start && !busy && !mode, PIPE_LAT, !result_valid)
	`CPG_ASSERT_IMP(a_strobe_needs_valid, result_valid, ctl_s[PIPE_LAT].v)
endmodule
`default_nettype wire

### tb/sv/tb_coons_patch_grid_checker.sv
// Checker for the Coons patch grid evaluator: watches the APB and item ports,
// predicts each vertex word and compares it with the result port. Depends on cpg_pkg.
module tb_coons_patch_grid_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	input  logic                 pready,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 mode,
	input  logic [1:0]           curve_select,
	input  logic [1:0]           point_select,
	input  cpg_pkg::coord_t      point_x,
	input  cpg_pkg::coord_t      point_y,
	input  cpg_pkg::coord_t      point_z,
	input  logic [7:0]           grid_i,
	input  logic [7:0]           grid_j,
	input  logic                 result_valid,
	input  logic [15:0]          vertex_index,
	input  cpg_pkg::coord_t      pos_x,
	input  cpg_pkg::coord_t      pos_y,
	input  cpg_pkg::coord_t      pos_z,
	input  logic [7:0]           color_r,
	input  logic [7:0]           color_g,
	input  logic [7:0]           color_b,
	output int                   mismatches,
	output int                   vertices_waiting,
	output int                   vertices_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import cpg_pkg::*;

	typedef struct packed {
		logic [15:0] vidx;
		coord_t      x;
		coord_t      y;
		coord_t      z;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
	} vertex_t;

	localparam longint UNIT = 65536;

	// shadow copies of the registers and the control point table
	logic [8:0] cols_reg;
	logic [8:0] rows_reg;
	longint     cp_tab [16][3];
	vertex_t    vertex_q[$];

	// round half up (towards +inf) then drop k bits
	function automatic longint round_drop(input longint v, input int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint clamp_dim(input logic [8:0] d);
		if (d < 2) return 2;
		if (d > 256) return 256;
		return longint'(d);
	endfunction

	// cubic Bezier point of one boundary curve, one axis, 8 extra fraction bits
	function automatic longint bezier_axis(input int c, input longint u, input int ax);
		longint v;
		longint bw[4];
		longint acc;
		v = UNIT - u;
		bw[0] = v * v * v;
		bw[1] = 3 * u * v * v;
		bw[2] = 3 * u * u * v;
		bw[3] = u * u * u;
		acc = 0;
		for (int k = 0; k < 4; k++)
			acc += ((bw[k] + (longint'(1) << 31)) >> 32) * cp_tab[c * 4 + k][ax];
		return round_drop(acc, 8);
	endfunction

	function automatic longint lerp16(input longint u, input longint a, input longint b);
		return (UNIT - u) * a + u * b;
	endfunction

	function automatic coord_t clip_coord(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return coord_t'(v);
	endfunction

	function automatic logic [7:0] colour_level(input longint w);
		return 8'((255 * w + (longint'(1) << 31)) >> 32);
	endfunction

	function automatic vertex_t predict_vertex(input logic [7:0] gi, input logic [7:0] gj);
		vertex_t vx;
		longint m, n, i, j, s, t, lc, ld, b0, b1, bb;
		coord_t p[3];
		m = clamp_dim(cols_reg);
		n = clamp_dim(rows_reg);
		i = (gi > m - 1) ? m - 1 : gi;
		j = (gj > n - 1) ? n - 1 : gj;
		s = (i * UNIT + (m - 1) / 2) / (m - 1);
		t = (j * UNIT + (n - 1) / 2) / (n - 1);
		for (int a = 0; a < 3; a++) begin
			lc = lerp16(t, bezier_axis(0, s, a), bezier_axis(1, s, a));
			ld = lerp16(s, bezier_axis(2, t, a), bezier_axis(3, t, a));
			b0 = round_drop(lerp16(s, cp_tab[0][a], cp_tab[3][a]), 8);
			b1 = round_drop(lerp16(s, cp_tab[4][a], cp_tab[7][a]), 8);
			bb = lerp16(t, b0, b1);
			p[a] = clip_coord(round_drop(lc + ld - bb, 24));
		end
		vx.vidx = 16'(i + j * m);
		vx.x = p[0];
		vx.y = p[1];
		vx.z = p[2];
		vx.r = colour_level((UNIT - s) * (UNIT - t) + s * t);
		vx.g = colour_level(t * UNIT);
		vx.b = colour_level(s * (UNIT - t));
		return vx;
	endfunction

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// observe both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		vertex_t want;
		if (!arst_n) begin
			cols_reg = 9'd20;
			rows_reg = 9'd20;
			for (int e = 0; e < 16; e++)
				for (int a = 0; a < 3; a++) cp_tab[e][a] = 0;
			vertex_q.delete();
			mismatches = 0;
			vertices_seen = 0;
			vertices_waiting = 0;
		end else begin
			// result word out
			if (result_valid) begin
				vertices_seen++;
				if (vertex_q.size() == 0) begin
					$display("%0t ns: unexpected vertex word, expected none, actual index %0d",
						$time, vertex_index);
					mismatches++;
				end else begin
					want = vertex_q.pop_front();
					compare_field("vertex_index", want.vidx, vertex_index);
					compare_field("pos_x", want.x, pos_x);
					compare_field("pos_y", want.y, pos_y);
					compare_field("pos_z", want.z, pos_z);
					compare_field("color_r", want.r, color_r);
					compare_field("color_g", want.g, color_g);
					compare_field("color_b", want.b, color_b);
				end
			end
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_COLUMNS) cols_reg = pwdata[8:0];
				else if (paddr[2] == REG_ROWS) rows_reg = pwdata[8:0];
			end
			// accepted item word
			if (start && !busy) begin
				if (!mode) begin
					cp_tab[{curve_select, point_select}][0] = point_x;
					cp_tab[{curve_select, point_select}][1] = point_y;
					cp_tab[{curve_select, point_select}][2] = point_z;
				end else
					vertex_q.push_back(predict_vertex(grid_i, grid_j));
			end
			vertices_waiting = vertex_q.size();
		end
	end
endmodule

### tb/sv/tb_coons_patch_grid_evaluator.sv
// Testbench top for the Coons patch grid evaluator: clock, reset, APB set-up and
// item stimulus. Depends on cpg_pkg, the block and tb_coons_patch_grid_checker.
module tb_coons_patch_grid_evaluator;
	timeunit 1ns;
	timeprecision 1ps;
	import cpg_pkg::*;

	localparam logic [2:0] ADDR_COLUMNS = {REG_COLUMNS, 2'b00};
	localparam logic [2:0] ADDR_ROWS    = {REG_ROWS, 2'b00};
	localparam int         ITEMS_PER_PHASE = 410;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic        mode = 1'b0;
	logic [1:0]  curve_select = '0, point_select = '0;
	coord_t      point_x = '0, point_y = '0, point_z = '0;
	logic [7:0]  grid_i = '0, grid_j = '0;
	logic        result_valid;
	logic [15:0] vertex_index;
	coord_t      pos_x, pos_y, pos_z;
	logic [7:0]  color_r, color_g, color_b;
	int          mismatches, vertices_waiting, vertices_seen;

	int          idle_pct;
	int          cur_m = 20, cur_n = 20;
	int          loads_sent, evals_sent, phase_items;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	coons_patch_grid_evaluator i_dut (.*);

	tb_coons_patch_grid_checker i_checker (.*);

	task automatic reg_write(input logic [2:0] addr, input int value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stop sending, let the pipe drain, then set the grid size
	task automatic set_grid(input int cols, input int rows);
		@(negedge clk);
		start <= 1'b0;
		while (vertices_waiting != 0) @(negedge clk);
		repeat (PIPE_LAT + 2) @(negedge clk);
		reg_write(ADDR_COLUMNS, cols);
		reg_write(ADDR_ROWS, rows);
		cur_m = (cols < 2) ? 2 : (cols > 256) ? 256 : cols;
		cur_n = (rows < 2) ? 2 : (rows > 256) ? 256 : rows;
	endtask

	// one item word; unused fields carry random noise
	task automatic send_word(input logic md, input logic [1:0] cs, input logic [1:0] ps,
		input coord_t x, input coord_t y, input coord_t z, input logic [7:0] gi,
		input logic [7:0] gj);
		@(negedge clk);
		while (int'($urandom_range(99)) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		mode <= md;
		curve_select <= cs;
		point_select <= ps;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		grid_i <= gi;
		grid_j <= gj;
		while (busy) @(negedge clk);
		@(posedge clk);
		if (md) evals_sent++;
		else loads_sent++;
		phase_items++;
	endtask

	task automatic load_point(input int e, input coord_t x, input coord_t y, input coord_t z);
		send_word(1'b0, 2'(e >> 2), 2'(e), x, y, z, 8'($urandom), 8'($urandom));
	endtask

	task automatic eval_vertex(input logic [7:0] gi, input logic [7:0] gj);
		send_word(1'b1, 2'($urandom), 2'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), gi, gj);
	endtask

	function automatic coord_t rand_coord(input bit narrow);
		if (narrow) return coord_t'(int'($urandom_range(4095)) - 2048);
		return coord_t'($urandom);
	endfunction

	// mostly whole patches followed by runs of vertices; some stray words
	task automatic random_phase();
		bit narrow;
		int pick;
		phase_items = 0;
		while (phase_items < ITEMS_PER_PHASE) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				narrow = $urandom_range(3) != 0;
				for (int e = 0; e < 16; e++)
					load_point(e, rand_coord(narrow), rand_coord(narrow), rand_coord(narrow));
				repeat ($urandom_range(20, 8)) begin
					if ($urandom_range(9) == 0) eval_vertex(8'($urandom), 8'($urandom));
					else eval_vertex(8'($urandom_range(cur_m)), 8'($urandom_range(cur_n)));
				end
			end else if (pick < 85)
				load_point($urandom_range(15), rand_coord(0), rand_coord(0), rand_coord(0));
			else
				eval_vertex(8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		idle_pct = 33;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, extreme points, grid corners and clamped indices
		eval_vertex(8'd0, 8'd0);
		eval_vertex(8'd255, 8'd255);
		for (int e = 0; e < 16; e++)
			load_point(e, (e % 2) ? 16'sh7fff : 16'sh8000, (e % 3 == 0) ? 16'sh7fff : 16'sh8000,
				coord_t'(e * 256));
		eval_vertex(8'd0, 8'd0);
		eval_vertex(8'd19, 8'd0);
		eval_vertex(8'd0, 8'd19);
		eval_vertex(8'd19, 8'd19);
		eval_vertex(8'd10, 8'd7);
		eval_vertex(8'd255, 8'd0);

		// phase one: wide and flat grid, sender idles often
		set_grid(256, 2);
		eval_vertex(8'd255, 8'd1);
		eval_vertex(8'd128, 8'd255);
		random_phase();

		// phase two: heavier sender gaps, tall grid
		idle_pct = 70;
		set_grid(2, 256);
		random_phase();

		// phase three: back to back, out-of-range sizes clamp
		idle_pct = 0;
		set_grid(511, 0);
		eval_vertex(8'd255, 8'd255);
		set_grid($urandom_range(30, 3), $urandom_range(30, 3));
		random_phase();

		@(negedge clk);
		start <= 1'b0;
		fork
			while (vertices_waiting != 0) @(negedge clk);
			repeat (20000) @(negedge clk);
		join_any
		disable fork;
		repeat (PIPE_LAT + 5) @(negedge clk);

		$display("Covered %0d control point loads and %0d vertex evaluations, %0d vertices checked,",
			loads_sent, evals_sent, vertices_seen);
		$display("grid sizes from 2 to 256 including clamped sizes and clamped indices.");
		if (mismatches == 0 && vertices_waiting == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule

### filelist.f
+incdir+sv
sv/cpg_pkg.sv
sv/coons_patch_grid_evaluator.sv
tb/sv/tb_coons_patch_grid_checker.sv
tb/sv/tb_coons_patch_grid_evaluator.sv
